[design/ectrm_pkg.sv]
// Shared types and constants for the cartridge timer / ROM mapper block.
// No dependencies; compiled first.
`default_nettype none

package ectrm_pkg;

    // defaults for the top-level parameters
    localparam int ROM_ADDR_BITS_DEF = 22;
    localparam int SCORE_SECONDS_DEF = 5;

    // field widths
    localparam int ADDR_W     = 24;
    localparam int DATA_W     = 8;
    localparam int ROM_SIZE_W = 23;
    localparam int OFFSET_W   = 22;
    localparam int NUM_ROMS   = 4;

    // APB register map
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam logic [2:0] REG_BOARD_KIND = 3'd0;
    localparam logic [2:0] REG_DIP        = 3'd1;
    localparam logic [2:0] REG_ROM0_SIZE  = 3'd2;
    localparam logic [2:0] REG_ROM1_SIZE  = 3'd3;
    localparam logic [2:0] REG_ROM2_SIZE  = 3'd4;
    localparam logic [2:0] REG_ROM3_SIZE  = 3'd5;

    // item commands
    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_READ  = 2'd1,
        CMD_WRITE = 2'd2,
        CMD_FETCH = 2'd3
    } t_cmd_code;

    // board decoding
    localparam logic [1:0] BOARD_FIRST  = 2'd0;
    localparam logic [1:0] BOARD_SECOND = 2'd1;

    // bus addresses
    localparam logic [23:0] ADDR_STATUS_A = 24'h106000;
    localparam logic [23:0] ADDR_STATUS_B = 24'hc00000;
    localparam logic [23:0] ADDR_SELECT_A = 24'h206000;
    localparam logic [23:0] ADDR_SELECT_B = 24'he00000;

    // select register codes
    localparam logic [7:0] SEL_ARM      = 8'h09;
    localparam logic [7:0] SEL_B0_ROM2  = 8'h05;
    localparam logic [7:0] SEL_B0_ROM3  = 8'h03;
    localparam logic [7:0] SEL_B1_ROM2  = 8'h0c;
    localparam logic [7:0] SEL_B1_ROM3  = 8'h0a;

    localparam logic [7:0] STATUS_TIME_OVER = 8'h02;
    localparam logic [4:0] BASE_MINUTES     = 5'd3;

    typedef struct packed {
        logic [1:0]                           board_kind;
        logic [7:0]                           dip;
        logic [NUM_ROMS-1:0][ROM_SIZE_W-1:0]  rom_size;
    } t_cfg;

    typedef struct packed {
        logic accept;    // latch item, update timer state, set up fold
        logic step;      // one mirroring iteration
        logic load_out;  // move finished result into output register
    } t_dp_cmd;

    typedef struct packed {
        logic fold_done;
    } t_dp_sts;

endpackage

`default_nettype wire

[design/ectrm_if.sv]
// Valid/ready channel interfaces for command items and result items.
// Depends on nothing.
`default_nettype none

interface ectrm_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [23:0] address;
    logic [7:0]  bus_data;

    modport source (output valid, output cmd, output address, output bus_data,
                    input ready);
    modport sink   (input valid, input cmd, input address, input bus_data,
                    output ready);
endinterface

interface ectrm_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  read_data;
    logic        rom_hit;
    logic [1:0]  rom_id;
    logic [21:0] rom_offset;
    logic        timer_running;
    logic        score_running;

    modport source (output valid, output read_data, output rom_hit, output rom_id,
                    output rom_offset, output timer_running, output score_running,
                    input ready);
    modport sink   (input valid, input read_data, input rom_hit, input rom_id,
                    input rom_offset, input timer_running, input score_running,
                    output ready);
endinterface

`default_nettype wire

[design/ectrm_cfg.sv]
// APB configuration registers: board kind, DIP switches, ROM chip sizes.
// Depends on ectrm_pkg.
`default_nettype none

module ectrm_cfg (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_psel,
    input  wire logic                               i_penable,
    input  wire logic                               i_pwrite,
    input  wire logic [ectrm_pkg::APB_ADDR_W-1:0]   i_paddr,
    input  wire logic [ectrm_pkg::APB_DATA_W-1:0]   i_pwdata,
    output logic      [ectrm_pkg::APB_DATA_W-1:0]   o_prdata,
    output ectrm_pkg::t_cfg                         o_cfg
);

    ectrm_pkg::t_cfg r_cfg;
    ectrm_pkg::t_cfg n_cfg;
    logic [2:0]      w_idx;
    logic            w_wr;

    assign w_idx = i_paddr[4:2];
    assign w_wr  = i_psel && i_penable && i_pwrite;

    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            case (w_idx)
                ectrm_pkg::REG_BOARD_KIND: n_cfg.board_kind  = i_pwdata[1:0];
                ectrm_pkg::REG_DIP:        n_cfg.dip         = i_pwdata[7:0];
                ectrm_pkg::REG_ROM0_SIZE:  n_cfg.rom_size[0] = i_pwdata[22:0];
                ectrm_pkg::REG_ROM1_SIZE:  n_cfg.rom_size[1] = i_pwdata[22:0];
                ectrm_pkg::REG_ROM2_SIZE:  n_cfg.rom_size[2] = i_pwdata[22:0];
                ectrm_pkg::REG_ROM3_SIZE:  n_cfg.rom_size[3] = i_pwdata[22:0];
                default: ;  // unmapped: ignored
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        case (w_idx)
            ectrm_pkg::REG_BOARD_KIND: o_prdata = {30'd0, r_cfg.board_kind};
            ectrm_pkg::REG_DIP:        o_prdata = {24'd0, r_cfg.dip};
            ectrm_pkg::REG_ROM0_SIZE:  o_prdata = {9'd0, r_cfg.rom_size[0]};
            ectrm_pkg::REG_ROM1_SIZE:  o_prdata = {9'd0, r_cfg.rom_size[1]};
            ectrm_pkg::REG_ROM2_SIZE:  o_prdata = {9'd0, r_cfg.rom_size[2]};
            ectrm_pkg::REG_ROM3_SIZE:  o_prdata = {9'd0, r_cfg.rom_size[3]};
            default:                   o_prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

[design/ectrm_ctrl.sv]
// Controller FSM: item acceptance, mirroring iterations, result hand-off.
// Depends on ectrm_pkg.
`default_nettype none

module ectrm_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output ectrm_pkg::t_dp_cmd     o_cmd,
    input  wire ectrm_pkg::t_dp_sts i_sts
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_FOLD = 3'b010,
        S_SEND = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_slot_free;

    assign w_slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state  = r_state;
        o_cmd    = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_FOLD;
                end
            end
            S_FOLD: begin
                if (i_sts.fold_done) begin
                    n_state = S_SEND;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            S_SEND: begin
                if (w_slot_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

[design/ectrm_dp.sv]
// Datapath: timer/score state, bus register decode, fetch decode and the
// bit-per-cycle address mirroring unit, plus the output register. Uses ectrm_pkg.
`default_nettype none

module ectrm_dp #(
    parameter int ROM_ADDR_BITS = ectrm_pkg::ROM_ADDR_BITS_DEF,
    parameter int SCORE_SECONDS = ectrm_pkg::SCORE_SECONDS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire ectrm_pkg::t_cfg   i_cfg,
    input  wire ectrm_pkg::t_dp_cmd i_cmd,
    output ectrm_pkg::t_dp_sts     o_sts,
    input  wire logic [1:0]        i_item_cmd,
    input  wire logic [23:0]       i_address,
    input  wire logic [7:0]        i_bus_data,
    output logic [7:0]             o_read_data,
    output logic                   o_rom_hit,
    output logic [1:0]             o_rom_id,
    output logic [21:0]            o_rom_offset,
    output logic                   o_timer_running,
    output logic                   o_score_running
);

    localparam logic [23:0] OFF_MASK   = 24'((64'd1 << ROM_ADDR_BITS) - 64'd1);
    localparam logic [2:0]  SCORE_INIT = 3'(SCORE_SECONDS);

    // persistent cartridge state
    logic [7:0]  r_select,       n_select;
    logic [7:0]  r_status,       n_status;
    logic        r_timer_active, n_timer_active;
    logic [10:0] r_timer_left,   n_timer_left;
    logic        r_score_active, n_score_active;
    logic [2:0]  r_score_left,   n_score_left;

    // per-item working registers
    logic [7:0]  r_rd,   n_rd;
    logic [1:0]  r_id,   n_id;
    logic        r_hit,  n_hit;
    logic [23:0] r_addr, n_addr;
    logic [22:0] r_size, n_size;
    logic [23:0] r_base;
    logic [23:0] r_mask;

    // output register
    logic [7:0]  r_out_rd;
    logic        r_out_hit;
    logic [1:0]  r_out_id;
    logic [21:0] r_out_off;
    logic        r_out_tr;
    logic        r_out_sr;

    logic [4:0]  w_minutes;
    logic [10:0] w_len;
    logic        w_mapped;
    logic [23:0] w_sum;
    logic [23:0] w_off;

    // (3 + dip[3:0]) * 60 as 64x - 4x
    assign w_minutes = ectrm_pkg::BASE_MINUTES + {1'b0, i_cfg.dip[3:0]};
    assign w_len     = {w_minutes, 6'd0} - {4'd0, w_minutes, 2'd0};

    always_comb begin
        n_select       = r_select;
        n_status       = r_status;
        n_timer_active = r_timer_active;
        n_timer_left   = r_timer_left;
        n_score_active = r_score_active;
        n_score_left   = r_score_left;
        n_rd           = i_bus_data;
        n_id           = 2'd0;
        n_addr         = i_address;
        w_mapped       = 1'b0;

        case (ectrm_pkg::t_cmd_code'(i_item_cmd))
            ectrm_pkg::CMD_TICK: begin
                // score countdown first, then the game timer
                if (r_score_active && r_score_left != 3'd0) begin
                    n_score_left = r_score_left - 3'd1;
                    if (n_score_left == 3'd0) begin
                        n_score_active = 1'b0;
                    end
                end
                if (r_timer_active && r_timer_left != 11'd0) begin
                    n_timer_left = r_timer_left - 11'd1;
                    if (n_timer_left == 11'd0) begin
                        n_timer_active = 1'b0;
                        n_status       = r_status | ectrm_pkg::STATUS_TIME_OVER;
                        n_score_active = 1'b1;
                        n_score_left   = SCORE_INIT;
                    end
                end
            end
            ectrm_pkg::CMD_READ: begin
                if (i_address == ectrm_pkg::ADDR_STATUS_A ||
                    i_address == ectrm_pkg::ADDR_STATUS_B) begin
                    n_rd = r_status;
                end
            end
            ectrm_pkg::CMD_WRITE: begin
                if (i_address == ectrm_pkg::ADDR_SELECT_A ||
                    i_address == ectrm_pkg::ADDR_SELECT_B) begin
                    n_select = i_bus_data;
                    if (i_bus_data == ectrm_pkg::SEL_ARM) begin
                        n_timer_active = 1'b1;
                        n_timer_left   = w_len;
                    end
                end
            end
            ectrm_pkg::CMD_FETCH: begin
                case (i_cfg.board_kind)
                    ectrm_pkg::BOARD_FIRST: begin
                        if (r_select == ectrm_pkg::SEL_ARM)     n_id = 2'd1;
                        if (r_select == ectrm_pkg::SEL_B0_ROM2) n_id = 2'd2;
                        if (r_select == ectrm_pkg::SEL_B0_ROM3) n_id = 2'd3;
                        if (i_address[23] && i_address[15])     n_id = 2'd0;
                        if (i_address[15]) begin
                            n_addr   = {2'd0, i_address[22:16], i_address[14:0]};
                            w_mapped = 1'b1;
                        end
                    end
                    ectrm_pkg::BOARD_SECOND: begin
                        if (r_select == ectrm_pkg::SEL_ARM)     n_id = 2'd1;
                        if (r_select == ectrm_pkg::SEL_B1_ROM2) n_id = 2'd2;
                        if (r_select == ectrm_pkg::SEL_B1_ROM3) n_id = 2'd3;
                        if (i_address[21] && i_address[15])     n_id = 2'd0;
                        if (i_address[22]) begin
                            n_addr   = {2'd0, i_address[21:0]};
                            w_mapped = 1'b1;
                        end else if (i_address[15]) begin
                            if (n_id != 2'd2) begin
                                n_addr = {4'd0, i_address[20:16], i_address[14:0]};
                            end else begin
                                n_addr = {3'd0, i_address[20:0]};
                            end
                            w_mapped = 1'b1;
                        end
                    end
                    default: ;  // no ROM mapping
                endcase
                if (!w_mapped) begin
                    n_id = 2'd0;
                end
            end
            default: ;
        endcase

        n_size = i_cfg.rom_size[n_id];
        n_hit  = w_mapped && (n_size != '0);
    end

    // mirroring: done at once for a non-hit item, else once the address falls below the size or bits run out
    assign o_sts.fold_done = !r_hit || (r_addr < {1'b0, r_size}) || (r_mask == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_select       <= '0;
            r_status       <= '0;
            r_timer_active <= 1'b0;
            r_timer_left   <= '0;
            r_score_active <= 1'b0;
            r_score_left   <= '0;
            r_hit          <= 1'b0;
        end else if (i_cmd.accept) begin
            r_select       <= n_select;
            r_status       <= n_status;
            r_timer_active <= n_timer_active;
            r_timer_left   <= n_timer_left;
            r_score_active <= n_score_active;
            r_score_left   <= n_score_left;
            r_hit          <= n_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_rd   <= n_rd;
            r_id   <= n_id;
            r_addr <= n_addr;
            r_size <= n_size;
            r_base <= '0;
            r_mask <= 24'h800000;
        end else if (i_cmd.step) begin
            if ((r_addr & r_mask) != '0) begin
                r_addr <= r_addr & ~r_mask;
                if ({1'b0, r_size} > r_mask) begin
                    r_size <= r_size - r_mask[22:0];
                    r_base <= r_base + r_mask;
                end
            end
            r_mask <= r_mask >> 1;
        end
    end

    assign w_sum = r_base + r_addr;
    assign w_off = w_sum & OFF_MASK;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_rd  <= r_rd;
            r_out_hit <= r_hit;
            r_out_id  <= r_id;
            r_out_off <= r_hit ? w_off[21:0] : 22'd0;
            r_out_tr  <= r_timer_active;
            r_out_sr  <= r_score_active;
        end
    end

    assign o_read_data     = r_out_rd;
    assign o_rom_hit       = r_out_hit;
    assign o_rom_id        = r_out_id;
    assign o_rom_offset    = r_out_off;
    assign o_timer_running = r_out_tr;
    assign o_score_running = r_out_sr;

endmodule

`default_nettype wire

[design/event_cart_timer_rom_mapper_unit.sv]
// Competition cartridge controller: game timer, score phase and ROM mapper.
// Depends on ectrm_pkg, ectrm_if, ectrm_cfg, ectrm_ctrl and ectrm_dp.
//
// Usage:
//   i_cmd_ch carries one item per handshake: cmd (tick, read, write, fetch),
//   a 24-bit bus address and a data byte. o_res_ch returns exactly one result
//   item for each: read data, ROM hit/id/offset and the timer/score flags.
//   Board kind, DIP switches and the four ROM sizes sit behind the APB port
//   (register i at byte 4*i); change them only while the block is idle.
// Sequencing:
//   One item in flight at a time. An item is taken in the idle state, then
//   the mirroring unit strips at most one address bit per cycle, 24 bit
//   positions from bit 23 down, then the result moves to the output register.
//   Ticks, reads, writes and misses go straight to the hand-off; a ROM hit
//   first walks the bit positions until its address falls below the ROM size.
// Stalls:
//   A finished result waits in the output register; the next item is still
//   accepted and processed, and only its hand-off waits for the slot.
// Reset:
//   i_rst_n is synchronous, active low. Clears timer, score, select and status
//   state, all configuration, and drops output valid.
`default_nettype none

module event_cart_timer_rom_mapper_unit #(
    parameter int ROM_ADDR_BITS = ectrm_pkg::ROM_ADDR_BITS_DEF,
    parameter int SCORE_SECONDS = ectrm_pkg::SCORE_SECONDS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    ectrm_in_if.sink                                i_cmd_ch,
    ectrm_out_if.source                             o_res_ch,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [ectrm_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [ectrm_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [ectrm_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                    pready
);

    ectrm_pkg::t_cfg    w_cfg;
    ectrm_pkg::t_dp_cmd w_cmd;
    ectrm_pkg::t_dp_sts w_sts;

    // zero-wait-state APB
    assign pready = 1'b1;

    ectrm_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_cfg     (w_cfg)
    );

    // sequencing: accept, iterate the mirroring unit, hand off
    ectrm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_cmd_ch.valid),
        .o_in_ready  (i_cmd_ch.ready),
        .o_out_valid (o_res_ch.valid),
        .i_out_ready (o_res_ch.ready),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    // timer state, decode and mirroring, output register
    ectrm_dp #(
        .ROM_ADDR_BITS (ROM_ADDR_BITS),
        .SCORE_SECONDS (SCORE_SECONDS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (w_cfg),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_item_cmd      (i_cmd_ch.cmd),
        .i_address       (i_cmd_ch.address),
        .i_bus_data      (i_cmd_ch.bus_data),
        .o_read_data     (o_res_ch.read_data),
        .o_rom_hit       (o_res_ch.rom_hit),
        .o_rom_id        (o_res_ch.rom_id),
        .o_rom_offset    (o_res_ch.rom_offset),
        .o_timer_running (o_res_ch.timer_running),
        .o_score_running (o_res_ch.score_running)
    );

    // only one item in flight: no second accept straight after the first
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd_ch.valid && i_cmd_ch.ready) |=> !i_cmd_ch.ready)
        else $error("item accepted while previous item still in progress");

    // a waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_out |-> (!o_res_ch.valid || o_res_ch.ready))
        else $error("output register loaded over an untaken result");

    // a miss carries no offset
    a_miss_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_ch.valid && !o_res_ch.rom_hit) |-> (o_res_ch.rom_offset == '0))
        else $error("non-zero ROM offset on a miss");

endmodule

`default_nettype wire
